// ----- src/ihex_chk_pkg.sv -----
// Shared types, constants and the hex digit decoder for the Intel HEX record checker.
// No dependencies; the parser, result register and top module import this package.
`timescale 1ns / 1ps
`default_nettype none

package ihex_chk_pkg;

   // ascii codes the parser reacts to
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_F     = 8'h46;

   // record types from this value up are rejected
   localparam logic [7:0] TYPE_LIMIT = 8'd6;

   // result codes
   typedef enum logic [2:0] {
      KIND_DATA      = 3'd0,
      KIND_OK        = 3'd1,
      KIND_CSUM_ERR  = 3'd2,
      KIND_BAD_START = 3'd3,
      KIND_BAD_TYPE  = 3'd4
   } kind_type;

   // one result transaction
   typedef struct packed {
      kind_type    kind;
      logic [15:0] address;
      logic [7:0]  data_byte;
      logic [7:0]  rec_type;
      logic [7:0]  rec_len;
   } result_type;

   // parser outcome for the character in the input register
   typedef struct packed {
      logic       has_result;
      result_type result;
   } step_type;

   // uppercase hex digit to value, anything else gives zero
   function automatic logic [3:0] decode_digit(input logic [7:0] c);
      logic [7:0] diff;
      begin
         diff = 8'd0;
         if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
            diff = c - CHAR_ZERO;
         end else if (c inside {[CHAR_A:CHAR_F]}) begin
            diff = c - CHAR_A + 8'd10;
         end
         decode_digit = diff[3:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- src/ihex_chk_intf.sv -----
// Valid/ready channel interfaces of the Intel HEX record checker.
// Depends on nothing; the request channel carries characters, the response channel results.
`timescale 1ns / 1ps
`default_nettype none

interface ihex_chk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;

   modport source (output valid, output char_in, input ready);
   modport sink   (input valid, input char_in, output ready);
endinterface

interface ihex_chk_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] address;
   logic [7:0]  data_byte;
   logic [7:0]  rec_type;
   logic [7:0]  rec_len;

   modport source (output valid, output kind, output address, output data_byte,
                   output rec_type, output rec_len, input ready);
   modport sink   (input valid, input kind, input address, input data_byte,
                   input rec_type, input rec_len, output ready);
endinterface

`default_nettype wire

// ----- src/ihex_chk_in_stage.sv -----
// Input register of the Intel HEX record checker: holds one character for the parser.
// Depends on no package.
`timescale 1ns / 1ps
`default_nettype none

module ihex_chk_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char,
   input  wire logic       advance,
   output logic            held_valid,
   output logic [7:0]      held_char
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;

   // free when empty or when the held character moves on this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (req_ready) begin
         valid_in = req_valid;
         char_in  = req_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign held_valid = valid_ff;
   assign held_char  = char_ff;

endmodule

`default_nettype wire

// ----- src/ihex_chk_parser.sv -----
// Record parser of the Intel HEX record checker: state and one-character step logic.
// Depends on ihex_chk_pkg for the digit decoder, result codes and step struct.
`timescale 1ns / 1ps
`default_nettype none

module ihex_chk_parser
   import ihex_chk_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] char_in,
   input  wire logic       advance,
   output step_type        step
);

   typedef enum logic [2:0] {
      PH_WAIT  = 3'd0,
      PH_COUNT = 3'd1,
      PH_ADDR  = 3'd2,
      PH_TYPE  = 3'd3,
      PH_DATA  = 3'd4,
      PH_CSUM  = 3'd5
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  upper_ff, upper_in;
   logic [1:0]  toggle_ff, toggle_in;
   logic [7:0]  count_ff, count_in;
   logic [15:0] base_ff, base_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  offset_ff, offset_in;
   logic [7:0]  sum_ff, sum_in;

   logic [3:0]  nib;
   logic [7:0]  byte_val;
   logic        byte_done;
   logic [7:0]  expect_sum;

   assign nib        = decode_digit(char_in);
   assign byte_val   = {upper_ff, nib};
   assign byte_done  = toggle_ff[0];
   assign expect_sum = 8'd0 - sum_ff;

   // one character step
   always_comb begin
      phase_in  = phase_ff;
      upper_in  = upper_ff;
      toggle_in = toggle_ff;
      count_in  = count_ff;
      base_in   = base_ff;
      type_in   = type_ff;
      offset_in = offset_ff;
      sum_in    = sum_ff;

      step.has_result        = 1'b0;
      step.result.kind       = KIND_DATA;
      step.result.address    = 16'd0;
      step.result.data_byte  = 8'd0;
      step.result.rec_type   = 8'd0;
      step.result.rec_len    = 8'd0;

      case (phase_ff)
         PH_COUNT, PH_ADDR, PH_TYPE, PH_DATA, PH_CSUM: begin
            // inside a record: assemble bytes from digit pairs
            if (phase_ff == PH_ADDR) begin
               base_in = {base_ff[11:0], nib};
            end
            if (!byte_done) begin
               upper_in = nib;
            end
            toggle_in = toggle_ff + 2'd1;
            if (byte_done) begin
               case (phase_ff)
                  PH_COUNT: begin
                     count_in  = byte_val;
                     sum_in    = sum_ff + byte_val;
                     phase_in  = PH_ADDR;
                     toggle_in = 2'd0;
                  end
                  PH_ADDR: begin
                     sum_in = sum_ff + byte_val;
                     if (toggle_ff == 2'd3) begin
                        phase_in  = PH_TYPE;
                        toggle_in = 2'd0;
                     end
                  end
                  PH_TYPE: begin
                     type_in   = byte_val;
                     sum_in    = sum_ff + byte_val;
                     toggle_in = 2'd0;
                     if (byte_val >= TYPE_LIMIT) begin
                        phase_in             = PH_WAIT;
                        step.has_result      = 1'b1;
                        step.result.kind     = KIND_BAD_TYPE;
                        step.result.address  = base_ff;
                        step.result.rec_type = byte_val;
                        step.result.rec_len  = count_ff;
                     end else begin
                        offset_in = 8'd0;
                        phase_in  = (count_ff == 8'd0) ? PH_CSUM : PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     sum_in                = sum_ff + byte_val;
                     offset_in             = offset_ff + 8'd1;
                     step.has_result       = 1'b1;
                     step.result.kind      = KIND_DATA;
                     step.result.address   = base_ff + {8'd0, offset_ff};
                     step.result.data_byte = byte_val;
                     step.result.rec_type  = type_ff;
                     step.result.rec_len   = count_ff;
                     if (offset_in == count_ff) begin
                        phase_in  = PH_CSUM;
                        toggle_in = 2'd0;
                     end
                  end
                  default: begin
                     // checksum byte closes the record
                     phase_in             = PH_WAIT;
                     toggle_in            = 2'd0;
                     step.has_result      = 1'b1;
                     step.result.kind     = (expect_sum == byte_val) ? KIND_OK
                                                                     : KIND_CSUM_ERR;
                     step.result.address  = base_ff;
                     step.result.rec_type = type_ff;
                     step.result.rec_len  = count_ff;
                  end
               endcase
            end
         end
         default: begin
            // waiting for the start colon
            if (char_in == CHAR_COLON) begin
               sum_in    = 8'd0;
               offset_in = 8'd0;
               base_in   = 16'd0;
               count_in  = 8'd0;
               type_in   = 8'd0;
               upper_in  = 4'd0;
               phase_in  = PH_COUNT;
               toggle_in = 2'd0;
            end else begin
               phase_in = PH_WAIT;
               if (char_in != CHAR_CR && char_in != CHAR_LF) begin
                  step.has_result  = 1'b1;
                  step.result.kind = KIND_BAD_START;
               end
            end
         end
      endcase
   end

   // state update when the held character is consumed
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_WAIT;
         upper_ff  <= 4'd0;
         toggle_ff <= 2'd0;
         count_ff  <= 8'd0;
         base_ff   <= 16'd0;
         type_ff   <= 8'd0;
         offset_ff <= 8'd0;
         sum_ff    <= 8'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         upper_ff  <= upper_in;
         toggle_ff <= toggle_in;
         count_ff  <= count_in;
         base_ff   <= base_in;
         type_ff   <= type_in;
         offset_ff <= offset_in;
         sum_ff    <= sum_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/ihex_chk_out_stage.sv -----
// Result register of the Intel HEX record checker: holds one result until taken.
// Depends on ihex_chk_pkg for the result struct.
`timescale 1ns / 1ps
`default_nettype none

module ihex_chk_out_stage
   import ihex_chk_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic load,
   input  result_type load_result,
   output logic       free,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output result_type rsp_result
);

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   // room for a new result when empty or being taken now
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (load) begin
         valid_in  = 1'b1;
         result_in = load_result;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ----- src/intel_hex_record_checker_unit.sv -----
// Intel HEX record checker: one ASCII character per transaction in, at most one result out.
// A result passes through the input register and then the result register before it is presented.
// Throughput: one character per cycle; a character that yields a result stalls while the
// result register is full and not being taken. The parser step lies between the two registers.
// Reset (synchronous, active high) empties both registers and returns the parser
// to waiting for a start colon with all record fields cleared.
`timescale 1ns / 1ps
`default_nettype none

module intel_hex_record_checker_unit
   import ihex_chk_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   ihex_chk_req_if.sink   req_chan,
   ihex_chk_rsp_if.source rsp_chan
);

   logic       held_valid;
   logic [7:0] held_char;
   logic       advance;
   logic       out_free;
   step_type   step;
   result_type rsp_result;

   // held character moves on unless it has a result and the result register is busy
   assign advance = held_valid && (!step.has_result || out_free);

   ihex_chk_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .req_char   (req_chan.char_in),
      .advance    (advance),
      .held_valid (held_valid),
      .held_char  (held_char)
   );

   ihex_chk_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .char_in (held_char),
      .advance (advance),
      .step    (step)
   );

   ihex_chk_out_stage u_out (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && step.has_result),
      .load_result (step.result),
      .free        (out_free),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_result  (rsp_result)
   );

   // result fields onto the response channel
   assign rsp_chan.kind      = rsp_result.kind;
   assign rsp_chan.address   = rsp_result.address;
   assign rsp_chan.data_byte = rsp_result.data_byte;
   assign rsp_chan.rec_type  = rsp_result.rec_type;
   assign rsp_chan.rec_len   = rsp_result.rec_len;

endmodule

`default_nettype wire
